// ===== rtl/core/ssrl_pkg.sv =====
// Package for the soft start ramp limiter: field widths, fixed-point constants,
// sequencer states, register indexes and the divider request and response types.
// No dependencies.
`default_nettype none

package ssrl_pkg;

  // Fixed-point format of the speed state and the clamp applied to targets.
  localparam int FRAC_BITS = 8;
  localparam int SPEED_MAX = 255;

  // Field widths.
  localparam int TGT_W  = 9;                     // integer target
  localparam int SPD_W  = TGT_W + FRAC_BITS;     // fixed-point speed
  localparam int DIFF_W = SPD_W + 1;             // target minus speed
  localparam int INC_W  = 16;                    // step increment register
  localparam int LIM_W  = 9;                     // speed limiter register
  localparam int CMD_W  = 9;                     // scaled command
  localparam int CFG_W  = 16;                    // configuration write data
  localparam int CFG_IDX_W = 2;

  // Shared multiplier: an 18 bit magnitude times a 16 bit operand.
  localparam int MUL_A_W = DIFF_W;
  localparam int MUL_B_W = INC_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // The quotient never exceeds the increment, so it has INC_W bits.
  localparam int QUO_W = INC_W;

  // Command = speed * limiter / (256 * 2^FRAC_BITS): a right shift.
  localparam int CMD_SHIFT = 8 + FRAC_BITS;
  localparam int CMD_MAG_W = CMD_W - 1;

  // Reset values of the registers.
  localparam logic [INC_W-1:0] STEP_INC_RESET = 16'd10445;
  localparam logic [LIM_W-1:0] LIM_FULL       = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_INC  = 2'd0,
    CFG_SOFT_EN   = 2'd1,
    CFG_SPEED_LIM = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL_L,
    ST_DIV_L,
    ST_MUL_R,
    ST_DIV_R,
    ST_UPDATE,
    ST_CMD_L,
    ST_CMD_R,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               start;
    logic [MUL_P_W-1:0] dividend;
    logic [DIFF_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/ssrl_div.sv =====
// Iterative restoring divider for the soft start ramp limiter, one quotient
// bit per cycle. Depends on ssrl_pkg.
`default_nettype none

module ssrl_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ssrl_pkg::div_req_t req,
  output ssrl_pkg::div_rsp_t     rsp
);

  localparam int CNT_W = $clog2(ssrl_pkg::QUO_W);

  // The dividend is below divisor * 2^QUO_W, so its upper part already sits
  // below the divisor and only QUO_W steps are needed.
  logic [ssrl_pkg::DIFF_W-1:0] rem;
  logic [ssrl_pkg::DIFF_W-1:0] divisor;
  logic [ssrl_pkg::QUO_W-1:0]  quo;
  logic [CNT_W-1:0]            cnt;
  logic                        busy;
  logic                        done;

  logic [ssrl_pkg::DIFF_W:0]   shifted;
  logic [ssrl_pkg::DIFF_W:0]   trial;

  assign shifted = {rem, quo[ssrl_pkg::QUO_W-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(ssrl_pkg::QUO_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.dividend[ssrl_pkg::MUL_P_W-1 -: ssrl_pkg::DIFF_W];
      quo     <= req.dividend[ssrl_pkg::QUO_W-1:0];
      divisor <= req.divisor;
    end else if (busy) begin
      if (!trial[ssrl_pkg::DIFF_W]) begin
        rem <= trial[ssrl_pkg::DIFF_W-1:0];
        quo <= {quo[ssrl_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem <= shifted[ssrl_pkg::DIFF_W-1:0];
        quo <= {quo[ssrl_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ===== rtl/core/soft_start_ramp_limiter.sv =====
// Top level of the two-channel soft start ramp limiter: sequencer, shared
// multiplier, speed state and output register. Depends on ssrl_pkg, ssrl_div.
//
// Usage. One input word carries the left and right integer targets and the
// brake and autonomous flags; it is taken at a rising edge with in_valid high
// and in_stall low. Each input word gives exactly one output word carrying the
// ramped speeds (fixed point, 8 fraction bits), the scaled commands and the
// flags, offered on out_valid and taken when out_stall is low.
// The three configuration registers are written through cfg_write, cfg_index
// and cfg_data; writes are expected only while the block is idle.
// When the speeds ramp, a word passes through evaluation, the left product and
// quotient, the right product and quotient, the update and the two command
// products; when they jump straight to the targets, evaluation leads directly
// to the command products. The ramp path rests on the single restoring divider
// and on the one multiplier that serves both ramp products and both commands in turn.
// One word is worked on at a time: in_stall stays high from acceptance until
// the result has been moved to the output register. A result still waiting in
// that register does not hold back the next input word; only a second result
// finding the register full waits, in the final sequencer state, until the
// receiver lowers out_stall.
// Synchronous reset clears the speeds and flags to zero, restores the register
// defaults (increment 10445, soft start on, limiter at full scale) and empties
// the output register.
`default_nettype none

module soft_start_ramp_limiter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                cfg_write,
  input  wire logic [ssrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ssrl_pkg::CFG_W-1:0]          cfg_data,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [ssrl_pkg::TGT_W-1:0]   target_left,
  input  wire logic signed [ssrl_pkg::TGT_W-1:0]   target_right,
  input  wire logic                                target_brake,
  input  wire logic                                target_autonomous,
  // output channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [ssrl_pkg::SPD_W-1:0]        actual_left,
  output logic signed [ssrl_pkg::SPD_W-1:0]        actual_right,
  output logic signed [ssrl_pkg::CMD_W-1:0]        left_command,
  output logic signed [ssrl_pkg::CMD_W-1:0]        right_command,
  output logic                                     brake_out,
  output logic                                     autonomous_out
);

  // Targets beyond the speed range saturate; only the most negative code can.
  function automatic logic signed [ssrl_pkg::TGT_W-1:0] clamp_target(
    input logic signed [ssrl_pkg::TGT_W-1:0] t
  );
    logic signed [ssrl_pkg::TGT_W-1:0] lim;
    lim = ssrl_pkg::TGT_W'(ssrl_pkg::SPEED_MAX);
    if (t > lim) begin
      return lim;
    end else if (t < -lim) begin
      return -lim;
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ssrl_pkg::INC_W-1:0] step_inc;
  logic                       soft_en;
  logic [ssrl_pkg::LIM_W-1:0] speed_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_inc  <= ssrl_pkg::STEP_INC_RESET;
      soft_en   <= 1'b1;
      speed_lim <= ssrl_pkg::LIM_FULL;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ssrl_pkg::CFG_STEP_INC: begin
          step_inc <= cfg_data[ssrl_pkg::INC_W-1:0];
        end
        ssrl_pkg::CFG_SOFT_EN: begin
          soft_en <= cfg_data[0];
        end
        ssrl_pkg::CFG_SPEED_LIM: begin
          // A limiter above full scale is held at full scale.
          if (cfg_data[ssrl_pkg::LIM_W-1:0] > ssrl_pkg::LIM_FULL) begin
            speed_lim <= ssrl_pkg::LIM_FULL;
          end else begin
            speed_lim <= cfg_data[ssrl_pkg::LIM_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  ssrl_pkg::state_t   state;
  ssrl_pkg::state_t   state_next;
  ssrl_pkg::div_req_t div_req;
  ssrl_pkg::div_rsp_t div_rsp;

  logic in_take;
  logic out_free;
  logic ramp;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssrl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      ssrl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ssrl_pkg::ST_EVAL;
        end
      end
      ssrl_pkg::ST_EVAL: begin
        state_next = ramp ? ssrl_pkg::ST_MUL_L : ssrl_pkg::ST_CMD_L;
      end
      ssrl_pkg::ST_MUL_L: begin
        state_next = ssrl_pkg::ST_DIV_L;
      end
      ssrl_pkg::ST_DIV_L: begin
        if (div_rsp.done) begin
          state_next = ssrl_pkg::ST_MUL_R;
        end
      end
      ssrl_pkg::ST_MUL_R: begin
        state_next = ssrl_pkg::ST_DIV_R;
      end
      ssrl_pkg::ST_DIV_R: begin
        if (div_rsp.done) begin
          state_next = ssrl_pkg::ST_UPDATE;
        end
      end
      ssrl_pkg::ST_UPDATE: begin
        state_next = ssrl_pkg::ST_CMD_L;
      end
      ssrl_pkg::ST_CMD_L: begin
        state_next = ssrl_pkg::ST_CMD_R;
      end
      ssrl_pkg::ST_CMD_R: begin
        state_next = ssrl_pkg::ST_FINISH;
      end
      ssrl_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = ssrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ssrl_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Speed state and ramp decision
  // ---------------------------------------------------------------------
  logic signed [ssrl_pkg::SPD_W-1:0] speed_left;
  logic signed [ssrl_pkg::SPD_W-1:0] speed_right;
  logic signed [ssrl_pkg::SPD_W-1:0] tgt_left;
  logic signed [ssrl_pkg::SPD_W-1:0] tgt_right;
  logic                              brake_state;
  logic                              auto_state;

  logic signed [ssrl_pkg::DIFF_W-1:0] diff_left;
  logic signed [ssrl_pkg::DIFF_W-1:0] diff_right;
  logic [ssrl_pkg::DIFF_W-1:0]        mag_left_c;
  logic [ssrl_pkg::DIFF_W-1:0]        mag_right_c;
  logic [ssrl_pkg::DIFF_W-1:0]        inc_ext;
  logic                               acc_left;
  logic                               acc_right;

  // Registered results of the evaluation step, and the two registered quotients.
  logic [ssrl_pkg::DIFF_W-1:0] mag_left;
  logic [ssrl_pkg::DIFF_W-1:0] mag_right;
  logic [ssrl_pkg::DIFF_W-1:0] mag_max;
  logic                        neg_left;
  logic                        neg_right;
  logic [ssrl_pkg::QUO_W-1:0]  quo_left;
  logic [ssrl_pkg::QUO_W-1:0]  quo_right;

  assign diff_left  = $signed({tgt_left[ssrl_pkg::SPD_W-1], tgt_left})
                    - $signed({speed_left[ssrl_pkg::SPD_W-1], speed_left});
  assign diff_right = $signed({tgt_right[ssrl_pkg::SPD_W-1], tgt_right})
                    - $signed({speed_right[ssrl_pkg::SPD_W-1], speed_right});

  assign mag_left_c  = diff_left[ssrl_pkg::DIFF_W-1]
                     ? ssrl_pkg::DIFF_W'(-diff_left) : ssrl_pkg::DIFF_W'(diff_left);
  assign mag_right_c = diff_right[ssrl_pkg::DIFF_W-1]
                     ? ssrl_pkg::DIFF_W'(-diff_right) : ssrl_pkg::DIFF_W'(diff_right);

  assign inc_ext = {{(ssrl_pkg::DIFF_W - ssrl_pkg::INC_W){1'b0}}, step_inc};

  // A side accelerates when the difference is non-zero and points the same
  // way as a non-zero target.
  assign acc_left  = (diff_left != '0) && (tgt_left != '0)
                   && (diff_left[ssrl_pkg::DIFF_W-1] == tgt_left[ssrl_pkg::SPD_W-1]);
  assign acc_right = (diff_right != '0) && (tgt_right != '0)
                   && (diff_right[ssrl_pkg::DIFF_W-1] == tgt_right[ssrl_pkg::SPD_W-1]);

  assign ramp = soft_en && (acc_left || acc_right)
              && ((mag_left_c > inc_ext) || (mag_right_c > inc_ext));

  // ---------------------------------------------------------------------
  // Shared multiplier: ramp products first, then the two commands.
  // ---------------------------------------------------------------------
  logic [ssrl_pkg::MUL_A_W-1:0] mul_a;
  logic [ssrl_pkg::MUL_B_W-1:0] mul_b;
  logic [ssrl_pkg::MUL_P_W-1:0] mul_p;
  logic [ssrl_pkg::SPD_W-1:0]   speed_mag_left;
  logic [ssrl_pkg::SPD_W-1:0]   speed_mag_right;
  logic [ssrl_pkg::MUL_B_W-1:0] lim_ext;

  assign speed_mag_left  = speed_left[ssrl_pkg::SPD_W-1]
                         ? ssrl_pkg::SPD_W'(-speed_left) : ssrl_pkg::SPD_W'(speed_left);
  assign speed_mag_right = speed_right[ssrl_pkg::SPD_W-1]
                         ? ssrl_pkg::SPD_W'(-speed_right) : ssrl_pkg::SPD_W'(speed_right);
  assign lim_ext = {{(ssrl_pkg::MUL_B_W - ssrl_pkg::LIM_W){1'b0}}, speed_lim};

  always_comb begin
    mul_a = mag_left;
    mul_b = step_inc;
    unique case (state)
      ssrl_pkg::ST_MUL_R: begin
        mul_a = mag_right;
      end
      ssrl_pkg::ST_CMD_L: begin
        mul_a = {1'b0, speed_mag_left};
        mul_b = lim_ext;
      end
      ssrl_pkg::ST_CMD_R: begin
        mul_a = {1'b0, speed_mag_right};
        mul_b = lim_ext;
      end
      default: begin
      end
    endcase
  end

  assign mul_p = ssrl_pkg::MUL_P_W'(mul_a) * ssrl_pkg::MUL_P_W'(mul_b);

  // The product goes straight into the divider's registers.
  assign div_req.start    = (state == ssrl_pkg::ST_MUL_L) || (state == ssrl_pkg::ST_MUL_R);
  assign div_req.dividend = mul_p;
  assign div_req.divisor  = mag_max;

  ssrl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Signed step from a quotient; truncation toward zero follows from
  // dividing the magnitudes.
  logic signed [ssrl_pkg::SPD_W-1:0] delta_left;
  logic signed [ssrl_pkg::SPD_W-1:0] delta_right;
  logic [ssrl_pkg::CMD_MAG_W-1:0]    cmd_mag;
  logic signed [ssrl_pkg::CMD_W-1:0] cmd_pos;

  assign delta_left  = neg_left  ? -$signed({1'b0, quo_left})  : $signed({1'b0, quo_left});
  assign delta_right = neg_right ? -$signed({1'b0, quo_right}) : $signed({1'b0, quo_right});

  assign cmd_mag = mul_p[ssrl_pkg::CMD_SHIFT +: ssrl_pkg::CMD_MAG_W];
  assign cmd_pos = $signed({1'b0, cmd_mag});

  logic signed [ssrl_pkg::CMD_W-1:0] cmd_left;
  logic signed [ssrl_pkg::CMD_W-1:0] cmd_right;
  logic signed [ssrl_pkg::TGT_W-1:0] clamp_left;
  logic signed [ssrl_pkg::TGT_W-1:0] clamp_right;

  assign clamp_left  = clamp_target(target_left);
  assign clamp_right = clamp_target(target_right);

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_left  <= '0;
      speed_right <= '0;
      brake_state <= 1'b0;
      auto_state  <= 1'b0;
    end else begin
      if (in_take) begin
        brake_state <= target_brake;
        auto_state  <= target_autonomous;
      end
      if (state == ssrl_pkg::ST_EVAL && !ramp) begin
        speed_left  <= tgt_left;
        speed_right <= tgt_right;
      end else if (state == ssrl_pkg::ST_UPDATE) begin
        speed_left  <= speed_left + delta_left;
        speed_right <= speed_right + delta_right;
      end
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    if (in_take) begin
      tgt_left  <= $signed({clamp_left, {ssrl_pkg::FRAC_BITS{1'b0}}});
      tgt_right <= $signed({clamp_right, {ssrl_pkg::FRAC_BITS{1'b0}}});
    end
    if (state == ssrl_pkg::ST_EVAL) begin
      mag_left  <= mag_left_c;
      mag_right <= mag_right_c;
      mag_max   <= (mag_left_c > mag_right_c) ? mag_left_c : mag_right_c;
      neg_left  <= diff_left[ssrl_pkg::DIFF_W-1];
      neg_right <= diff_right[ssrl_pkg::DIFF_W-1];
    end
    if (state == ssrl_pkg::ST_DIV_L && div_rsp.done) begin
      quo_left <= div_rsp.quotient;
    end
    if (state == ssrl_pkg::ST_DIV_R && div_rsp.done) begin
      quo_right <= div_rsp.quotient;
    end
    if (state == ssrl_pkg::ST_CMD_L) begin
      cmd_left <= speed_left[ssrl_pkg::SPD_W-1] ? -cmd_pos : cmd_pos;
    end
    if (state == ssrl_pkg::ST_CMD_R) begin
      cmd_right <= speed_right[ssrl_pkg::SPD_W-1] ? -cmd_pos : cmd_pos;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic out_load;

  assign out_load = (state == ssrl_pkg::ST_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      actual_left    <= speed_left;
      actual_right   <= speed_right;
      left_command   <= cmd_left;
      right_command  <= cmd_right;
      brake_out      <= brake_state;
      autonomous_out <= auto_state;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_soft_start_ramp_limiter.sv =====
// Self-checking testbench for soft_start_ramp_limiter: random bursts of input words and a
// stalling receiver, with every output word checked against an in-bench ramp predictor.
// Depends on ssrl_pkg and the soft_start_ramp_limiter RTL.

module tb_soft_start_ramp_limiter;
  import ssrl_pkg::*;

  // One input word and one output word, packed in port order.
  typedef struct packed {
    logic [TGT_W-1:0] tl;
    logic [TGT_W-1:0] tr;
    logic             brake;
    logic             autonomous;
  } word_t;

  typedef struct packed {
    logic [SPD_W-1:0] al;
    logic [SPD_W-1:0] ar;
    logic [CMD_W-1:0] cl;
    logic [CMD_W-1:0] cr;
    logic             brake;
    logic             autonomous;
  } result_t;

  // Index 3 is not a register; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // Longer than the ramp path, so this leaves room for any late word.
  localparam int SETTLE_CYCLES = 50;
  localparam int TIMEOUT = 6_000_000;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 125;

  logic clk;
  logic rst = 1'b1;

  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [TGT_W-1:0] target_left = '0;
  logic [TGT_W-1:0] target_right = '0;
  logic             target_brake = 1'b0;
  logic             target_autonomous = 1'b0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [SPD_W-1:0] actual_left;
  logic [SPD_W-1:0] actual_right;
  logic [CMD_W-1:0] left_command;
  logic [CMD_W-1:0] right_command;
  logic             brake_out;
  logic             autonomous_out;

  soft_start_ramp_limiter i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .target_left       (target_left),
    .target_right      (target_right),
    .target_brake      (target_brake),
    .target_autonomous (target_autonomous),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .actual_left       (actual_left),
    .actual_right      (actual_right),
    .left_command      (left_command),
    .right_command     (right_command),
    .brake_out         (brake_out),
    .autonomous_out    (autonomous_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Words waiting to be offered, and output words predicted but not yet seen.
  word_t   pending_words[$];
  result_t expected_results[$];

  // The bench's own copy of the registers, mirrored as each write lands.
  logic [INC_W-1:0] cfg_step_inc = STEP_INC_RESET;
  logic             cfg_soft_en = 1'b1;
  logic [LIM_W-1:0] cfg_limiter = LIM_FULL;

  // Predicted speeds, one bit wider than the output so that nothing wraps.
  logic signed [SPD_W:0] speed_l = '0;
  logic signed [SPD_W:0] speed_r = '0;

  int  mismatch_count = 0;
  int  result_index = 0;
  logic in_taken = 1'b0;

  // Advances the predicted speeds by one tick and returns the output word that the
  // tick should produce. A side counts as accelerating when its distance to the
  // target has the same sign as the target itself; only then does the ramp apply,
  // and only when soft start is on and some distance exceeds the increment. Both
  // sides are scaled by the larger distance, so they arrive at their targets together.
  function automatic result_t ramp_tick(word_t w);
    longint t_l, t_r, d_l, d_r, m_l, m_r, s_l, s_r, step, span, c_l, c_r;
    result_t r;
    t_l = longint'($signed(w.tl));
    t_r = longint'($signed(w.tr));
    if (t_l > SPEED_MAX) t_l = SPEED_MAX;
    else if (t_l < -SPEED_MAX) t_l = -SPEED_MAX;
    if (t_r > SPEED_MAX) t_r = SPEED_MAX;
    else if (t_r < -SPEED_MAX) t_r = -SPEED_MAX;
    t_l = t_l * (longint'(1) << FRAC_BITS);
    t_r = t_r * (longint'(1) << FRAC_BITS);
    s_l = longint'(speed_l);
    s_r = longint'(speed_r);
    d_l = t_l - s_l;
    d_r = t_r - s_r;
    m_l = (d_l < 0) ? -d_l : d_l;
    m_r = (d_r < 0) ? -d_r : d_r;
    step = longint'(cfg_step_inc);
    if (((d_l > 0 && t_l > 0) || (d_l < 0 && t_l < 0) ||
         (d_r > 0 && t_r > 0) || (d_r < 0 && t_r < 0)) &&
        (m_l > step || m_r > step) && cfg_soft_en) begin
      span = (m_l > m_r) ? m_l : m_r;
      s_l = s_l + (step * d_l) / span;
      s_r = s_r + (step * d_r) / span;
    end else begin
      s_l = t_l;
      s_r = t_r;
    end
    speed_l = s_l[SPD_W:0];
    speed_r = s_r[SPD_W:0];
    // Signed division truncates towards zero, as the command scaling requires.
    c_l = (s_l * longint'(cfg_limiter)) / (longint'(256) << FRAC_BITS);
    c_r = (s_r * longint'(cfg_limiter)) / (longint'(256) << FRAC_BITS);
    r.al = s_l[SPD_W-1:0];
    r.ar = s_r[SPD_W-1:0];
    r.cl = c_l[CMD_W-1:0];
    r.cr = c_r[CMD_W-1:0];
    r.brake = w.brake;
    r.autonomous = w.autonomous;
    return r;
  endfunction

  // Monitor. Every accepted input word is run through the predictor at once, and
  // every accepted output word is checked against the oldest prediction. A word
  // passes at least the evaluation, command and final states before its output is
  // loaded, so it is never predicted and checked at the same edge.
  always @(posedge clk) begin : monitor
    result_t seen;
    result_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_results.push_back(ramp_tick({target_left, target_right,
                                              target_brake, target_autonomous}));
      end
      if (out_valid && !out_stall) begin
        seen = {actual_left, actual_right, left_command, right_command,
                brake_out, autonomous_out};
        if (expected_results.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $display("output word %0d arrived with nothing expected", result_index);
          end
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
              $display("word %0d expected L %0d R %0d cmd %0d/%0d brake %b auto %b",
                       result_index, $signed(want.al), $signed(want.ar),
                       $signed(want.cl), $signed(want.cr), want.brake, want.autonomous);
              $display("word %0d got      L %0d R %0d cmd %0d/%0d brake %b auto %b",
                       result_index, $signed(seen.al), $signed(seen.ar),
                       $signed(seen.cl), $signed(seen.cr), seen.brake, seen.autonomous);
            end
          end
        end
        result_index = result_index + 1;
      end
    end
  end

  // Driver. Words go out in bursts of random length separated by random gaps; the
  // long gaps are there so that new words also land while the block is idle or
  // half way through a ramp. A word that has not been taken is held unchanged.
  int    gap_left = 0;
  int    burst_left = 0;
  word_t next_word;

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        target_left <= next_word.tl;
        target_right <= next_word.tr;
        target_brake <= next_word.brake;
        target_autonomous <= next_word.autonomous;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(0, 11);
          case ($urandom_range(0, 7))
            0, 1, 2: gap_left = 0;
            3, 4, 5: gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(10, 60);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. The stall behaviour changes at random intervals between never
  // stalling, light random stalls, heavy random stalls and strict alternation.
  int stall_mode = 0;
  int stall_span = 0;

  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 300);
    end else begin
      stall_span = stall_span - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ~out_stall;
    endcase
  end

  task automatic send(input int tl, input int tr, input bit brake, input bit autonomous);
    word_t w;
    w.tl = tl[TGT_W-1:0];
    w.tr = tr[TGT_W-1:0];
    w.brake = brake;
    w.autonomous = autonomous;
    pending_words.push_back(w);
  endtask

  // Registers may only change while the block is idle: wait until every word has
  // gone in and every expected word has come out, then allow the ramp latency.
  task automatic settle();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_STEP_INC:  cfg_step_inc = data;
      CFG_SOFT_EN:   cfg_soft_en = data[0];
      CFG_SPEED_LIM: cfg_limiter = (data[LIM_W-1:0] > LIM_FULL) ? LIM_FULL
                                                                 : data[LIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_controls(input logic [CFG_W-1:0] inc, input logic [CFG_W-1:0] enable,
                              input logic [CFG_W-1:0] limiter);
    write_reg(CFG_STEP_INC, inc);
    write_reg(CFG_SOFT_EN, enable);
    write_reg(CFG_SPEED_LIM, limiter);
  endtask

  // Targets favour the extremes, zero and the out-of-range value -256.
  function automatic logic [TGT_W-1:0] pick_target();
    logic [31:0] rnd;
    rnd = $urandom;
    case (rnd[31:29])
      3'd0: return TGT_W'(255);
      3'd1: return TGT_W'(-255);
      3'd2: return '0;
      3'd3: return TGT_W'(-256);
      default: return rnd[TGT_W-1:0];
    endcase
  endfunction

  // Most of the traffic holds a target pair for a stretch of ticks so that the
  // ramps run to completion or get cut short; the rest is single random words.
  task automatic queue_random(input int count);
    int left;
    int len;
    word_t w;
    logic [31:0] rnd;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        rnd = $urandom;
        w = rnd[2*TGT_W+1:0];
        pending_words.push_back(w);
        left = left - 1;
      end else begin
        w.tl = pick_target();
        w.tr = pick_target();
        w.brake = $urandom_range(0, 1);
        w.autonomous = $urandom_range(0, 1);
        len = $urandom_range(1, 24);
        while (len > 0 && left > 0) begin
          if ($urandom_range(0, 7) == 0) w.brake = ~w.brake;
          if ($urandom_range(0, 7) == 0) w.autonomous = ~w.autonomous;
          pending_words.push_back(w);
          len = len - 1;
          left = left - 1;
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words under the reset settings: a ramp to full forward, the
    // out-of-range target on each side, a reversal, a drop to zero and mixed signs.
    send(0, 0, 0, 0);
    send(255, 255, 1, 1);
    send(255, 255, 1, 1);
    send(255, 255, 0, 1);
    send(-256, 255, 0, 1);
    send(255, -256, 1, 0);
    send(-255, -255, 0, 0);
    send(-255, -255, 0, 0);
    send(0, 0, 1, 1);
    send(100, -37, 0, 1);
    send(-1, 1, 1, 0);
    send(0, 255, 0, 0);
    settle();

    // A zero increment: an accelerating side must hold its speed.
    write_reg(CFG_STEP_INC, '0);
    send(200, -200, 1, 1);
    send(200, -200, 0, 1);
    send(0, 0, 0, 0);
    send(-255, 0, 1, 0);
    settle();

    // A limiter write above full scale saturates, and the largest increment.
    write_reg(CFG_STEP_INC, '1);
    write_reg(CFG_SPEED_LIM, 16'h01FF);
    send(255, -255, 1, 0);
    send(-128, 127, 0, 1);
    send(-256, -256, 1, 1);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: set_controls(STEP_INC_RESET, 16'd1, 16'(LIM_FULL));
        1: set_controls(16'd0, 16'd1, 16'd200);
        2: set_controls(16'hFFFF, 16'hFFFF, 16'd128);
        3: set_controls(16'd1, 16'd1, 16'hFFFF);
        4: set_controls(16'd300, 16'hFFFE, 16'd0);
        5: begin
          set_controls(16'($urandom), 16'($urandom), 16'($urandom));
          write_reg(CFG_SPARE, 16'($urandom));
        end
        6: set_controls(16'd2560, 16'd1, 16'd255);
        default: set_controls(16'($urandom), 16'd1, 16'($urandom_range(0, 256)));
      endcase
      queue_random(WORDS_PER_PHASE);
    end
    settle();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: many times the slowest correct run.
  initial begin
    #(TIMEOUT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
